FILE: src/slpg_pkg.sv
// Shared constants, register indexes, mode codes and cosine table builder for the pattern source.
package slpg_pkg;

  localparam int COORD_BITS_DEF    = 12;
  localparam int PHASE_BITS_DEF    = 16;
  localparam int COS_ADDR_BITS_DEF = 10;

  localparam int FRAME_BITS     = 13;
  localparam int WIDTH_BITS     = 12;
  localparam int INC_BITS       = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_MODE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRIPE_AXIS     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRIPE_WIDTH    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_NUMBER  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_BIT_COUNT  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT    = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 3'd7;

  localparam logic [1:0] MODE_FRINGE       = 2'd0;
  localparam logic [1:0] MODE_GRAY         = 2'd1;
  localparam logic [1:0] MODE_INVERSE_GRAY = 2'd2;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Taylor series divisors for the cosine and sine terms past the first.
  localparam longint COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};
  localparam longint SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  // One table entry: 127 + 128*cos of the entry's angle, truncated and clamped.
  // Only evaluated at elaboration; the sum that is shifted right is always nonnegative.
  function automatic logic [7:0] cos_entry(input int unsigned addr, input int unsigned abits);
    int unsigned qb;
    longint      q;
    longint      r;
    longint      x;
    longint      x2;
    longint      term_c;
    longint      sum_c;
    longint      term_s;
    longint      sum_s;
    longint      v;
    longint      t;
    qb     = abits - 2;
    q      = longint'((addr >> qb) & 3);
    r      = longint'(addr & ((1 << qb) - 1));
    x      = (r * HALF_PI_Q30) >>> qb;
    x2     = (x * x) >>> 30;
    term_c = Q30_ONE;
    sum_c  = term_c;
    term_s = x;
    sum_s  = x;
    for (int n = 0; n < 7; n++) begin
      term_c = ((term_c * x2) >>> 30) / COS_DIV[n];
      term_s = ((term_s * x2) >>> 30) / SIN_DIV[n];
      if ((n % 2) == 0) begin
        sum_c = sum_c - term_c;
        sum_s = sum_s - term_s;
      end else begin
        sum_c = sum_c + term_c;
        sum_s = sum_s + term_s;
      end
    end
    if (q == 0) v = sum_c;
    else if (q == 1) v = -sum_s;
    else if (q == 2) v = -sum_c;
    else v = sum_s;
    t = ((v + 2 * Q30_ONE) >>> 23) - 129;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

endpackage

FILE: src/structured_light_pattern_generator_unit.sv
// Raster pattern source: fringe and Gray code stripe pixels with coordinates, one per item.
//
// Usage: each item accepted on the input channel (in_valid/in_ready, field restart)
// produces exactly one pixel item on the output channel (out_valid/out_ready) carrying
// pixel_value, pixel_column, pixel_row and frame_last. Pixels follow row-major order;
// restart set in an item moves the raster back to pixel (0,0) before that pixel is made.
// The pixel computed from an accepted item sits in the output register at the next edge.
// Throughput is one item per cycle while the receiver takes pixels, set by the single pass
// through the counters, the phase adder and the cosine table lookup.
// When the receiver stalls, the output register holds its pixel and in_ready drops;
// in_ready is high whenever the output register is empty or is being emptied.
// Configuration goes through cfg_write/cfg_index/cfg_data and takes effect at once;
// write it only while no pixel is pending.
// Reset clears the raster counters, the stripe trackers and the phase accumulator,
// empties the output register and loads the default register values.
module structured_light_pattern_generator_unit #(
  parameter int COORD_BITS          = slpg_pkg::COORD_BITS_DEF,
  parameter int PHASE_BITS          = slpg_pkg::PHASE_BITS_DEF,
  parameter int COS_TABLE_ADDR_BITS = slpg_pkg::COS_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [slpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [slpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          pixel_value,
  output logic [COORD_BITS-1:0]               pixel_column,
  output logic [COORD_BITS-1:0]               pixel_row,
  output logic                                frame_last
);
  import slpg_pkg::*;

  localparam int COS_DEPTH = 1 << COS_TABLE_ADDR_BITS;
  localparam int SZ_BITS   = ((FRAME_BITS > COORD_BITS) ? FRAME_BITS : COORD_BITS) + 1;
  localparam int OW        = ((COORD_BITS + 1) > WIDTH_BITS) ? (COORD_BITS + 1) : WIDTH_BITS;
  localparam int GI_BITS   = $clog2(COORD_BITS);

  // Configuration registers.
  logic [1:0]            pattern_mode;
  logic                  stripe_axis;
  logic [WIDTH_BITS-1:0] stripe_width;
  logic [3:0]            pattern_number;
  logic [3:0]            code_bit_count;
  logic [FRAME_BITS-1:0] frame_width;
  logic [FRAME_BITS-1:0] frame_height;
  logic [INC_BITS-1:0]   phase_increment;

  // Raster and axis state.
  logic [COORD_BITS-1:0] column_count, column_count_next;
  logic [COORD_BITS-1:0] row_count, row_count_next;
  logic [COORD_BITS-1:0] offset_in_stripe, offset_in_stripe_next;
  logic [COORD_BITS-1:0] stripe_index, stripe_index_next;
  logic [PHASE_BITS-1:0] phase_accumulator, phase_accumulator_next;

  logic                  accept;
  logic [COORD_BITS-1:0] cur_col, cur_row, cur_off, cur_idx;
  logic [PHASE_BITS-1:0] cur_acc;
  logic [COORD_BITS-1:0] last_col, last_row;
  logic                  col_end, row_end;
  logic [OW-1:0]         off_inc;
  logic [COORD_BITS-1:0] off_step, idx_step;
  logic [PHASE_BITS-1:0] acc_step;
  logic [7:0]            value;

  logic [COORD_BITS-1:0]          stripe_masked, gray_code;
  logic [3:0]                     gray_pos;
  logic                           gray_bit;
  logic [1:0]                     quarter;
  logic [PHASE_BITS-1:0]          phase;
  logic [COS_TABLE_ADDR_BITS-1:0] cos_addr;
  logic [7:0]                     cos_rom [COS_DEPTH];

  generate
    for (genvar a = 0; a < COS_DEPTH; a++) begin : g_cos
      localparam logic [7:0] ENTRY = cos_entry(a, COS_TABLE_ADDR_BITS);
      assign cos_rom[a] = ENTRY;
    end
  endgenerate

  // Last coordinate of a frame dimension: size zero acts as one pixel and sizes
  // beyond the coordinate range saturate.
  function automatic logic [COORD_BITS-1:0] last_index(input logic [FRAME_BITS-1:0] size);
    logic [SZ_BITS-1:0] m1;
    m1 = SZ_BITS'(size) - SZ_BITS'(1);
    if (size == '0) return '0;
    if (m1 > SZ_BITS'({COORD_BITS{1'b1}})) return {COORD_BITS{1'b1}};
    return m1[COORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode    <= MODE_FRINGE;
      stripe_axis     <= 1'b0;
      stripe_width    <= WIDTH_BITS'(16);
      pattern_number  <= 4'd0;
      code_bit_count  <= 4'd6;
      frame_width     <= FRAME_BITS'(1024);
      frame_height    <= FRAME_BITS'(768);
      phase_increment <= INC_BITS'(4096);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_MODE:    pattern_mode    <= cfg_data[1:0];
        REG_STRIPE_AXIS:     stripe_axis     <= cfg_data[0];
        REG_STRIPE_WIDTH:    stripe_width    <= cfg_data[WIDTH_BITS-1:0];
        REG_PATTERN_NUMBER:  pattern_number  <= cfg_data[3:0];
        REG_CODE_BIT_COUNT:  code_bit_count  <= cfg_data[3:0];
        REG_FRAME_WIDTH:     frame_width     <= cfg_data[FRAME_BITS-1:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data[FRAME_BITS-1:0];
        REG_PHASE_INCREMENT: phase_increment <= cfg_data[INC_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // A restart clears the raster before this item's pixel is formed.
  assign cur_col = restart ? '0 : column_count;
  assign cur_row = restart ? '0 : row_count;
  assign cur_off = restart ? '0 : offset_in_stripe;
  assign cur_idx = restart ? '0 : stripe_index;
  assign cur_acc = restart ? '0 : phase_accumulator;

  assign last_col = last_index(frame_width);
  assign last_row = last_index(frame_height);
  assign col_end  = cur_col >= last_col;
  assign row_end  = cur_row >= last_row;

  assign off_inc  = OW'(cur_off) + OW'(1);
  assign off_step = (off_inc >= OW'(stripe_width)) ? '0 : off_inc[COORD_BITS-1:0];
  assign idx_step = (off_inc >= OW'(stripe_width)) ? cur_idx + COORD_BITS'(1) : cur_idx;
  assign acc_step = cur_acc + PHASE_BITS'(phase_increment);

  always_comb begin
    column_count_next      = cur_col + COORD_BITS'(1);
    row_count_next         = cur_row;
    offset_in_stripe_next  = cur_off;
    stripe_index_next      = cur_idx;
    phase_accumulator_next = cur_acc;
    if (col_end) begin
      column_count_next = '0;
      if (row_end || !stripe_axis) begin
        offset_in_stripe_next  = '0;
        stripe_index_next      = '0;
        phase_accumulator_next = '0;
      end else begin
        offset_in_stripe_next  = off_step;
        stripe_index_next      = idx_step;
        phase_accumulator_next = acc_step;
      end
      row_count_next = row_end ? '0 : cur_row + COORD_BITS'(1);
    end else if (!stripe_axis) begin
      offset_in_stripe_next  = off_step;
      stripe_index_next      = idx_step;
      phase_accumulator_next = acc_step;
    end
  end

  // Gray code of the low code_bit_count bits of the stripe number, read MSB first.
  always_comb begin
    for (int i = 0; i < COORD_BITS; i++) begin
      stripe_masked[i] = cur_idx[i] && (32'(i) < 32'(code_bit_count));
    end
  end

  assign gray_code = stripe_masked ^ (stripe_masked >> 1);
  assign gray_pos  = code_bit_count - 4'd1 - pattern_number;
  assign gray_bit  = (pattern_number < code_bit_count) && (32'(gray_pos) < COORD_BITS) &&
                     gray_code[gray_pos[GI_BITS-1:0]];

  // Phase step k adds (k+1) quarter turns.
  assign quarter = pattern_number[1:0] + 2'd1;
  assign phase   = {cur_acc[PHASE_BITS-1 -: 2] + quarter, cur_acc[PHASE_BITS-3:0]};

  generate
    if (PHASE_BITS >= COS_TABLE_ADDR_BITS) begin : g_addr_top
      assign cos_addr = phase[PHASE_BITS-1 -: COS_TABLE_ADDR_BITS];
    end else begin : g_addr_pad
      assign cos_addr = {phase, {(COS_TABLE_ADDR_BITS - PHASE_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    unique case (pattern_mode)
      MODE_FRINGE:       value = cos_rom[cos_addr];
      MODE_GRAY:         value = {8{gray_bit}};
      MODE_INVERSE_GRAY: value = ~{8{gray_bit}};
      default:           value = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= '0;
      row_count         <= '0;
      offset_in_stripe  <= '0;
      stripe_index      <= '0;
      phase_accumulator <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        column_count      <= column_count_next;
        row_count         <= row_count_next;
        offset_in_stripe  <= offset_in_stripe_next;
        stripe_index      <= stripe_index_next;
        phase_accumulator <= phase_accumulator_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_value  <= value;
      pixel_column <= cur_col;
      pixel_row    <= cur_row;
      frame_last   <= col_end && row_end;
    end
  end

  // An accepted item always shows up in the output register in the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item did not reach the output register");

  // A restarted item is emitted at the frame origin.
  a_restart_origin: assert property (@(posedge clk) disable iff (rst)
    accept && restart |=> pixel_column == '0 && pixel_row == '0)
    else $error("restart item not emitted at pixel zero zero");

  // Stripe modes only ever produce full black or full white.
  a_stripe_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid && pattern_mode != MODE_FRINGE |-> pixel_value == 8'd0 || pixel_value == 8'd255)
    else $error("stripe pixel is not black or white");

  // The frame origin after a completed frame: the next pixel starts at column and row zero.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && col_end && row_end |=> column_count == '0 && row_count == '0)
    else $error("raster did not wrap after the last pixel of the frame");

endmodule

FILE: verif/testbench.sv
// Self-checking bench for the structured light pattern source: predicted pixels vs. the DUT.
`timescale 1ns / 1ps

class raster_predictor;
  typedef struct packed {
    logic [7:0]  value;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
  } pixel_t;

  // Register copies, written alongside the DUT's configuration port.
  logic [1:0]  mode;
  logic        axis;
  logic [11:0] stripe_width;
  logic [3:0]  pattern_number;
  logic [3:0]  code_bits;
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [15:0] phase_step;

  logic [11:0] column_count;
  logic [11:0] row_count;
  logic [11:0] offset_in_stripe;
  logic [11:0] stripe_index;
  logic [15:0] phase_acc;

  logic [7:0] cos_levels [1024];
  pixel_t     pending_pixels [$];
  int         errors;
  int         checked;
  int         frames;

  function new();
    mode           = slpg_pkg::MODE_FRINGE;
    axis           = 1'b0;
    stripe_width   = 12'd16;
    pattern_number = 4'd0;
    code_bits      = 4'd6;
    frame_width    = 13'd1024;
    frame_height   = 13'd768;
    phase_step     = 16'd4096;
    column_count   = '0;
    row_count      = '0;
    clear_axis();
    for (int a = 0; a < 1024; a++) cos_levels[a] = cos_level(a);
    errors  = 0;
    checked = 0;
    frames  = 0;
  endfunction

  // 127 + 128*cos of the table angle in Q30 fixed point, truncated and clamped to a byte.
  function logic [7:0] cos_level(int unsigned addr);
    longint rem;
    longint x;
    longint xsq;
    longint cterm;
    longint sterm;
    longint csum;
    longint ssum;
    longint v;
    longint t;
    rem   = longint'(addr % 256);
    x     = rem * slpg_pkg::HALF_PI_Q30 / 256;
    xsq   = x * x / slpg_pkg::Q30_ONE;
    cterm = slpg_pkg::Q30_ONE;
    csum  = cterm;
    sterm = x;
    ssum  = x;
    for (int n = 1; n <= 7; n++) begin
      cterm = cterm * xsq / slpg_pkg::Q30_ONE / longint'((2 * n - 1) * (2 * n));
      sterm = sterm * xsq / slpg_pkg::Q30_ONE / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        csum = csum - cterm;
        ssum = ssum - sterm;
      end else begin
        csum = csum + cterm;
        ssum = ssum + sterm;
      end
    end
    case (addr / 256)
      0: v = csum;
      1: v = -ssum;
      2: v = -csum;
      default: v = ssum;
    endcase
    t = (v + 2 * slpg_pkg::Q30_ONE) / 8388608 - 129;
    if (t < 0) t = 0;
    else if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function void write_register(logic [2:0] index, logic [15:0] data);
    case (index)
      slpg_pkg::REG_PATTERN_MODE:    mode           = data[1:0];
      slpg_pkg::REG_STRIPE_AXIS:     axis           = data[0];
      slpg_pkg::REG_STRIPE_WIDTH:    stripe_width   = data[11:0];
      slpg_pkg::REG_PATTERN_NUMBER:  pattern_number = data[3:0];
      slpg_pkg::REG_CODE_BIT_COUNT:  code_bits      = data[3:0];
      slpg_pkg::REG_FRAME_WIDTH:     frame_width    = data[12:0];
      slpg_pkg::REG_FRAME_HEIGHT:    frame_height   = data[12:0];
      slpg_pkg::REG_PHASE_INCREMENT: phase_step     = data;
      default: ;
    endcase
  endfunction

  function void clear_axis();
    offset_in_stripe = '0;
    stripe_index     = '0;
    phase_acc        = '0;
  endfunction

  // A zero stripe width behaves like width one: every step starts a new stripe.
  function void step_axis();
    if ({1'b0, offset_in_stripe} + 13'd1 >= {1'b0, stripe_width}) begin
      offset_in_stripe = '0;
      stripe_index     = stripe_index + 12'd1;
    end else begin
      offset_in_stripe = offset_in_stripe + 12'd1;
    end
    phase_acc = phase_acc + phase_step;
  endfunction

  // Zero counts as one pixel; anything past the coordinate range saturates.
  function logic [11:0] last_index(logic [12:0] size);
    if (size == 13'd0) return 12'd0;
    if (size - 13'd1 > 13'd4095) return 12'hFFF;
    return 12'(size - 13'd1);
  endfunction

  function logic [7:0] gray_level();
    int unsigned stripe;
    int unsigned code;
    if (pattern_number >= code_bits) return 8'd0;
    stripe = stripe_index & ((32'd1 << code_bits) - 32'd1);
    code   = stripe ^ (stripe >> 1);
    return code[code_bits - 4'd1 - pattern_number] ? 8'd255 : 8'd0;
  endfunction

  function void note_request(logic restart_frame);
    pixel_t      px;
    logic [15:0] phase;
    logic [3:0]  step_index;
    logic        col_end;
    logic        row_end;
    if (restart_frame) begin
      column_count = '0;
      row_count    = '0;
      clear_axis();
    end
    step_index = pattern_number + 4'd1;
    phase      = phase_acc + {step_index[1:0], 14'd0};
    case (mode)
      slpg_pkg::MODE_FRINGE:       px.value = cos_levels[phase[15:6]];
      slpg_pkg::MODE_GRAY:         px.value = gray_level();
      slpg_pkg::MODE_INVERSE_GRAY: px.value = 8'd255 - gray_level();
      default:                     px.value = 8'd0;
    endcase
    col_end   = column_count >= last_index(frame_width);
    row_end   = row_count >= last_index(frame_height);
    px.column = column_count;
    px.row    = row_count;
    px.last   = col_end && row_end;
    pending_pixels = {pending_pixels, px};
    if (col_end) begin
      column_count = '0;
      if (row_end) begin
        row_count = '0;
        clear_axis();
      end else begin
        row_count = row_count + 12'd1;
        if (axis) step_axis();
        else clear_axis();
      end
    end else begin
      column_count = column_count + 12'd1;
      if (!axis) step_axis();
    end
  endfunction

  function void check_pixel(logic [7:0] value, logic [11:0] column, logic [11:0] row,
                            logic last);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      $error("pixel at column %0d row %0d arrived with none outstanding", column, row);
      errors++;
      return;
    end
    want = pending_pixels.pop_front();
    checked++;
    if (want.last) frames++;
    if (value !== want.value) begin
      $error("pixel_value: expected %0d, actual %0d", want.value, value);
      errors++;
    end
    if (column !== want.column) begin
      $error("pixel_column: expected %0d, actual %0d", want.column, column);
      errors++;
    end
    if (row !== want.row) begin
      $error("pixel_row: expected %0d, actual %0d", want.row, row);
      errors++;
    end
    if (last !== want.last) begin
      $error("frame_last: expected %0d, actual %0d", want.last, last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import slpg_pkg::*;

  // Pattern mode three has no package name; the DUT should output black for it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic        axis;
    logic [11:0] width;
    logic [3:0]  number;
    logic [3:0]  bits;
    logic [12:0] cols;
    logic [12:0] rows;
    logic [15:0] step;
  } settings_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      restart   = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                pixel_value;
  logic [11:0]               pixel_column;
  logic [11:0]               pixel_row;
  logic                      frame_last;

  int send_gap_pct  = 0;
  int stall_pct     = 0;
  int setting_count = 0;

  raster_predictor raster;

  structured_light_pattern_generator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_value  (pixel_value),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .frame_last   (frame_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready)
      raster.check_pixel(pixel_value, pixel_column, pixel_row, frame_last);
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    raster.write_register(index, data);
  endtask

  task automatic load_settings(settings_t s);
    write_reg(REG_PATTERN_MODE, 16'(s.mode));
    write_reg(REG_STRIPE_AXIS, 16'(s.axis));
    write_reg(REG_STRIPE_WIDTH, 16'(s.width));
    write_reg(REG_PATTERN_NUMBER, 16'(s.number));
    write_reg(REG_CODE_BIT_COUNT, 16'(s.bits));
    write_reg(REG_FRAME_WIDTH, 16'(s.cols));
    write_reg(REG_FRAME_HEIGHT, 16'(s.rows));
    write_reg(REG_PHASE_INCREMENT, s.step);
    cfg_write <= 1'b0;
    setting_count++;
  endtask

  // Leaves in_valid high after the item is taken; the caller lowers it when done.
  task automatic send_pixel(logic restart_frame);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_frame;
    do @(posedge clk); while (!in_ready);
    raster.note_request(restart_frame);
  endtask

  task automatic wait_drained();
    while (raster.pending_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(settings_t s, int count, logic lead_restart, int restart_pct);
    load_settings(s);
    send_pixel(lead_restart);
    repeat (count - 1) send_pixel($urandom_range(99) < restart_pct);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Mostly small frames and narrow stripes so frames and stripe codes wrap often.
  function automatic settings_t random_settings();
    settings_t   s;
    int unsigned pick;
    pick   = $urandom_range(9);
    s.mode = (pick < 3) ? MODE_FRINGE : (pick < 6) ? MODE_GRAY :
             (pick < 9) ? MODE_INVERSE_GRAY : MODE_UNUSED;
    s.axis = 1'($urandom_range(1));
    pick   = $urandom_range(9);
    if (pick < 7) s.width = 12'($urandom_range(0, 6));
    else if (pick < 9) s.width = 12'($urandom_range(7, 80));
    else s.width = $urandom_range(1) ? 12'd4095 : 12'($urandom);
    s.bits   = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    s.number = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(0, s.bits));
    pick     = $urandom_range(9);
    if (pick < 8) s.cols = 13'($urandom_range(1, 12));
    else if (pick < 9) s.cols = 13'd0;
    else s.cols = 13'($urandom_range(13, 8191));
    pick = $urandom_range(9);
    if (pick < 8) s.rows = 13'($urandom_range(1, 6));
    else if (pick < 9) s.rows = 13'd0;
    else s.rows = 13'($urandom_range(7, 8191));
    if ($urandom_range(1)) s.step = (s.width == 0) ? 16'd0 : 16'(65536 / s.width);
    else s.step = 16'($urandom);
    return s;
  endfunction

  initial begin
    settings_t s;
    raster        = new();
    send_gap_pct  = 10;
    stall_pct     = 75;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: a cosine fringe over a 1024 by 768 frame.
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Zero stripe width, and stripe numbers spanning a two bit code.
    s = '{MODE_GRAY, 1'b0, 12'd0, 4'd0, 4'd2, 13'd4, 13'd2, 16'd0};
    run_phase(s, 5, 1'b1, 0);
    // Bit index past the code length, zero sized frame along both dimensions.
    s = '{MODE_INVERSE_GRAY, 1'b1, 12'd3, 4'd5, 4'd3, 13'd0, 13'd0, 16'd100};
    run_phase(s, 2, 1'b0, 0);
    // Mode three, oversized frame that saturates, widest stripe and phase step.
    s = '{MODE_UNUSED, 1'b0, 12'd4095, 4'd15, 4'd15, 13'd8191, 13'd8191, 16'd65535};
    run_phase(s, 4, 1'b1, 0);
    // Shrinking the frame leaves the column counter past the new end; it must wrap.
    s = '{MODE_FRINGE, 1'b0, 12'd4095, 4'd15, 4'd15, 13'd3, 13'd8191, 16'd65535};
    run_phase(s, 2, 1'b0, 0);
    s = '{MODE_FRINGE, 1'b1, 12'd1, 4'd2, 4'd6, 13'd2, 13'd3, 16'd65535};
    run_phase(s, 6, 1'b1, 0);

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_gap_pct = 75;
        stall_pct    = 10;
      end else if (p == 6) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      run_phase(random_settings(), 72, 1'($urandom_range(1)), 3);
    end

    $display("Checked %0d pixels under %0d register settings, %0d of them closing a frame.",
             raster.checked, setting_count, raster.frames);
    $display("Covered fringe, Gray, inverse and unused modes on both axes with restarts.");
    if (raster.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end
endmodule
